>>> rtl/core/itrd_pkg.sv
// Shared types and constants for the integer to radix digits converter.
`default_nettype none
package itrd_pkg;

  localparam int unsigned MaxSymbols = 16;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 64;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned StackAw    = 5;
  localparam int unsigned CntW       = 6;

  localparam logic [7:0] PlusByte  = 8'h2B;
  localparam logic [7:0] MinusByte = 8'h2D;

  // register indexes (paddr[4:3])
  localparam logic [1:0] RegAlphaLow  = 2'd0;
  localparam logic [1:0] RegAlphaHigh = 2'd1;
  localparam logic [1:0] RegSymCount  = 2'd2;

  typedef struct packed {
    logic [127:0] alphabet;
    logic [4:0]   radix;
    logic         ok;
  } itrd_cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic div_step;
    logic div_push;
    logic emit_sign;
    logic emit_digit;
  } itrd_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic div_done;
    logic stack_one;
    logic slot_free;
  } itrd_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/itrd_regs.sv
// APB configuration registers and alphabet validity check.
`default_nettype none
module itrd_regs #(
  parameter int unsigned MaxSymbols = itrd_pkg::MaxSymbols
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [itrd_pkg::AddrW-1:0]  paddr,
  input  wire logic [itrd_pkg::DataW-1:0]  pwdata,
  output logic      [itrd_pkg::DataW-1:0]  prdata,
  output logic                             pready,
  output itrd_pkg::itrd_cfg_t              cfg_o
);

  logic [63:0]  alpha_lo_q;
  logic [63:0]  alpha_hi_q;
  logic [4:0]   count_q;
  logic         ok_q;
  logic         ok_d;
  logic         wr;
  logic [1:0]   idx;
  logic [127:0] alpha;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:3];
  assign alpha  = {alpha_hi_q, alpha_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
      count_q    <= '0;
    end else if (wr) begin
      case (idx)
        itrd_pkg::RegAlphaLow:  alpha_lo_q <= pwdata;
        itrd_pkg::RegAlphaHigh: alpha_hi_q <= pwdata;
        itrd_pkg::RegSymCount:  count_q    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // symbol count range, pairwise duplicate check plus sign bytes; the result is registered
  always_comb begin
    ok_d = (count_q >= 5'd2) && (count_q <= 5'(MaxSymbols));
    for (int i = 0; i < 16; i++) begin
      if ((5'(i) < count_q) &&
          ((alpha[8*i +: 8] == itrd_pkg::PlusByte) ||
           (alpha[8*i +: 8] == itrd_pkg::MinusByte))) begin
        ok_d = 1'b0;
      end
      for (int j = i + 1; j < 16; j++) begin
        if ((5'(j) < count_q) && (alpha[8*i +: 8] == alpha[8*j +: 8])) begin
          ok_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  always_comb begin
    case (idx)
      itrd_pkg::RegAlphaLow:  prdata = alpha_lo_q;
      itrd_pkg::RegAlphaHigh: prdata = alpha_hi_q;
      itrd_pkg::RegSymCount:  prdata = {59'd0, count_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.alphabet = alpha;
  assign cfg_o.radix    = count_q;
  assign cfg_o.ok       = ok_q;

endmodule
`default_nettype wire

>>> rtl/core/itrd_dp.sv
// Datapath: magnitude, 8-bit-per-cycle divider, digit stack, output register.
`default_nettype none
module itrd_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [31:0]          value_i,
  input  wire logic                 out_ready_i,
  input  itrd_pkg::itrd_cfg_t       cfg_i,
  input  itrd_pkg::itrd_cmd_t       cmd_i,
  output itrd_pkg::itrd_stat_t      stat_o,
  output logic                      out_valid_o,
  output logic [7:0]                symbol_o,
  output logic                      last_o
);

  logic [31:0]                   m_q;
  logic                          neg_q;
  logic [3:0]                    rem_q;
  logic [itrd_pkg::CntW-1:0]     cnt_q;
  logic [3:0]                    stack_q [itrd_pkg::StackDepth];
  logic [3:0]                    top_digit_q;
  logic                          out_valid_q;
  logic [7:0]                    symbol_q;
  logic                          last_q;

  logic [3:0]                    rem_d;
  logic [7:0]                    q8;
  logic [31:0]                   quo_d;
  logic [itrd_pkg::CntW-1:0]     top_idx;
  logic [itrd_pkg::StackAw-1:0]  below_idx;
  logic                          slot_free;

  // eight restoring division steps on the top byte of the shifting word
  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    r  = rem_q;
    q8 = '0;
    for (int j = 0; j < 8; j++) begin
      t = {r, m_q[31-j]};
      if (t >= cfg_i.radix) begin
        t         = t - cfg_i.radix;
        q8[7-j]   = 1'b1;
      end
      r = t[3:0];
    end
    rem_d = r;
    quo_d = {m_q[23:0], q8};
  end

  assign top_idx   = cnt_q - 1'b1;
  assign below_idx = top_idx[itrd_pkg::StackAw-1:0] - 1'b1;
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q <= value_i;
    end else if (cmd_i.start) begin
      neg_q <= m_q[31];
      m_q   <= m_q[31] ? 32'(32'd0 - m_q) : m_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      m_q   <= quo_d;
      rem_q <= cmd_i.div_push ? 4'd0 : rem_d;
    end
  end

  // digit stack; the top entry is held in a register for the emitter
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.div_push) begin
      stack_q[cnt_q[itrd_pkg::StackAw-1:0]] <= rem_d;
      top_digit_q                           <= rem_d;
    end else if (cmd_i.emit_digit) begin
      top_digit_q <= stack_q[below_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step && cmd_i.div_push) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.emit_digit) begin
      cnt_q <= top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      symbol_q <= itrd_pkg::MinusByte;
      last_q   <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      symbol_q <= cfg_i.alphabet[8*top_digit_q +: 8];
      last_q   <= (cnt_q == itrd_pkg::CntW'(1));
    end
  end

  assign stat_o.alpha_ok  = cfg_i.ok;
  assign stat_o.neg       = neg_q;
  assign stat_o.div_done  = (quo_d == 32'd0) ||
                            (cnt_q == itrd_pkg::CntW'(itrd_pkg::StackDepth - 1));
  assign stat_o.stack_one = (cnt_q == itrd_pkg::CntW'(1));
  assign stat_o.slot_free = slot_free;

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

>>> rtl/core/itrd_ctrl.sv
// Controller state machine: accept, check, divide per digit, emit bytes.
`default_nettype none
module itrd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  itrd_pkg::itrd_stat_t stat_i,
  output itrd_pkg::itrd_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StSign  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (!stat_i.alpha_ok) begin
          state_d = StIdle;
        end else begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == 2'd3) begin
          cmd_o.div_push = 1'b1;
          if (stat_i.div_done) begin
            state_d = stat_i.neg ? StSign : StEmit;
          end
        end
      end
      StSign: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (stat_i.stack_one) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/integer_to_radix_digits_top.sv
// Top level of the signed integer to radix digits converter.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   value_i[31:0] (signed)
//  out       output     out_valid_o / out_ready_i symbol_o[7:0], last_o
//  config    input      APB psel/penable/pwrite   64-bit regs at 0x00, 0x08, 0x10
//
// One item at a time. The item is accepted and the alphabet checked, then each
// digit is divided out of the 32-bit magnitude (8 quotient bits per cycle), then
// a minus sign for a negative value and the digits go out, each byte once the
// output register is empty or out_ready_i is high. Radix 2 gives the most digits, 32.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds its byte; the digit emitter waits on the output register.
`default_nettype none
module integer_to_radix_digits_top #(
  parameter int unsigned MaxSymbols = itrd_pkg::MaxSymbols
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [31:0]          value_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       symbol_o,
  output logic                             last_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [itrd_pkg::AddrW-1:0]  paddr,
  input  wire logic [itrd_pkg::DataW-1:0]  pwdata,
  output logic      [itrd_pkg::DataW-1:0]  prdata,
  output logic                             pready
);

  itrd_pkg::itrd_cfg_t  cfg;
  itrd_pkg::itrd_cmd_t  cmd;
  itrd_pkg::itrd_stat_t stat;

  // alphabet, radix and the registered validity flag
  itrd_regs #(
    .MaxSymbols (MaxSymbols)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing of one item
  itrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // divider, digit stack and output register
  itrd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .out_ready_i (out_ready_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

  // busy right after an item is taken
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again while an item is in work");

  // bytes only go into a free output register
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sign || cmd.emit_digit) |-> stat.slot_free)
    else $error("output register overwritten");

  // the final byte returns the controller to idle
  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_digit && stat.stack_one |=> in_ready_o)
    else $error("controller not idle after last byte");

  // a minus sign is never flagged last
  a_sign_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_sign |=> out_valid_o && !last_o)
    else $error("sign byte flagged last");

endmodule
`default_nettype wire
